>>> rtl/kpc_pkg.sv
// Shared types and constants of the keypad press classifier.
`timescale 1ns / 1ps

package kpc_pkg;

  localparam int NUM_KEYS     = 6;
  localparam int PIN_W        = 5;
  localparam int LIMIT_W      = 8;
  localparam int PERIOD_W     = 7;
  localparam int REL_W        = 2;
  localparam int ADDR_W       = 5;
  localparam int DATA_W       = 32;
  localparam int IDX_W        = 3;

  localparam int FILTER_TICKS = 2;
  localparam int SHORT_TICKS  = 5;
  localparam logic [REL_W-1:0] REL_MAX = 2'd3;

  // Key lanes
  localparam int KEY_ON          = 0;
  localparam int KEY_C1          = 1;
  localparam int KEY_C2          = 2;
  localparam int KEY_ADVANCE     = 3;
  localparam int KEY_C1_C2       = 4;
  localparam int KEY_C1_ADVANCE  = 5;

  // Register reset values
  localparam logic [PIN_W-1:0]    MASK_ON_RST         = 5'd1;
  localparam logic [PIN_W-1:0]    MASK_C1_RST         = 5'd2;
  localparam logic [PIN_W-1:0]    MASK_C2_RST         = 5'd4;
  localparam logic [PIN_W-1:0]    MASK_ADVANCE_RST    = 5'd8;
  localparam logic [PIN_W-1:0]    MASK_C1_C2_RST      = 5'd6;
  localparam logic [PIN_W-1:0]    MASK_C1_ADVANCE_RST = 5'd10;
  localparam logic [LIMIT_W-1:0]  LONG_LIMIT_RST      = 8'd120;
  localparam logic [PERIOD_W-1:0] REPEAT_PERIOD_RST   = 7'd30;

  typedef enum logic [IDX_W-1:0] {
    REG_MASK_ON         = 3'd0,
    REG_MASK_C1         = 3'd1,
    REG_MASK_C2         = 3'd2,
    REG_MASK_ADVANCE    = 3'd3,
    REG_MASK_C1_C2      = 3'd4,
    REG_MASK_C1_ADVANCE = 3'd5,
    REG_LONG_LIMIT      = 3'd6,
    REG_REPEAT_PERIOD   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] long_limit;
    logic [LIMIT_W-1:0] reload;
  } timing_cfg_t;

  typedef struct packed {
    logic ev;
    logic lg;
    logic active;
  } lane_stat_t;

endpackage

>>> rtl/kpc_if.sv
// Valid/ready channel interfaces for pin samples and classified events.
`timescale 1ns / 1ps

interface kpc_in_if import kpc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIN_W-1:0] raw_keys;

  modport source (output valid, output raw_keys, input ready);
  modport sink   (input valid, input raw_keys, output ready);
endinterface

interface kpc_out_if import kpc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [NUM_KEYS-1:0] event_mask;
  logic [NUM_KEYS-1:0] long_mask;

  modport source (output valid, output event_mask, output long_mask, input ready);
  modport sink   (input valid, input event_mask, input long_mask, output ready);
endinterface

>>> rtl/kpc_regs.sv
// APB configuration registers: key pin masks and press timing.
`timescale 1ns / 1ps

module kpc_regs import kpc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready,
  output logic [PIN_W-1:0]  key_mask [NUM_KEYS],
  output timing_cfg_t       timing
);

  logic [PIN_W-1:0]    mask_r [NUM_KEYS];
  logic [LIMIT_W-1:0]  long_limit_r;
  logic [PERIOD_W-1:0] repeat_period_r;
  logic                wr_en;
  reg_idx_t            idx;
  logic [LIMIT_W-1:0]  period_ext;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign idx        = reg_idx_t'(cfg_paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r[KEY_ON]         <= MASK_ON_RST;
      mask_r[KEY_C1]         <= MASK_C1_RST;
      mask_r[KEY_C2]         <= MASK_C2_RST;
      mask_r[KEY_ADVANCE]    <= MASK_ADVANCE_RST;
      mask_r[KEY_C1_C2]      <= MASK_C1_C2_RST;
      mask_r[KEY_C1_ADVANCE] <= MASK_C1_ADVANCE_RST;
      long_limit_r           <= LONG_LIMIT_RST;
      repeat_period_r        <= REPEAT_PERIOD_RST;
    end else if (wr_en) begin
      case (idx)
        REG_MASK_ON:         mask_r[KEY_ON]         <= cfg_pwdata[PIN_W-1:0];
        REG_MASK_C1:         mask_r[KEY_C1]         <= cfg_pwdata[PIN_W-1:0];
        REG_MASK_C2:         mask_r[KEY_C2]         <= cfg_pwdata[PIN_W-1:0];
        REG_MASK_ADVANCE:    mask_r[KEY_ADVANCE]    <= cfg_pwdata[PIN_W-1:0];
        REG_MASK_C1_C2:      mask_r[KEY_C1_C2]      <= cfg_pwdata[PIN_W-1:0];
        REG_MASK_C1_ADVANCE: mask_r[KEY_C1_ADVANCE] <= cfg_pwdata[PIN_W-1:0];
        REG_LONG_LIMIT:      long_limit_r           <= cfg_pwdata[LIMIT_W-1:0];
        REG_REPEAT_PERIOD:   repeat_period_r        <= cfg_pwdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MASK_ON:         cfg_prdata = DATA_W'(mask_r[KEY_ON]);
      REG_MASK_C1:         cfg_prdata = DATA_W'(mask_r[KEY_C1]);
      REG_MASK_C2:         cfg_prdata = DATA_W'(mask_r[KEY_C2]);
      REG_MASK_ADVANCE:    cfg_prdata = DATA_W'(mask_r[KEY_ADVANCE]);
      REG_MASK_C1_C2:      cfg_prdata = DATA_W'(mask_r[KEY_C1_C2]);
      REG_MASK_C1_ADVANCE: cfg_prdata = DATA_W'(mask_r[KEY_C1_ADVANCE]);
      REG_LONG_LIMIT:      cfg_prdata = DATA_W'(long_limit_r);
      REG_REPEAT_PERIOD:   cfg_prdata = DATA_W'(repeat_period_r);
      default:             cfg_prdata = '0;
    endcase
  end

  assign key_mask = mask_r;

  // Reload point after a long press, clamped at zero
  assign period_ext        = LIMIT_W'(repeat_period_r);
  assign timing.long_limit = long_limit_r;
  assign timing.reload     = (long_limit_r > period_ext) ? long_limit_r - period_ext : '0;

endmodule

>>> rtl/kpc_lane.sv
// One key lane: press/release counters, long-press flag and event decision.
`timescale 1ns / 1ps

module kpc_lane import kpc_pkg::*; #(
  parameter int COUNT_BITS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [PIN_W-1:0] raw_keys,
  input  logic [PIN_W-1:0] mask,
  input  logic             combo_clr,
  input  timing_cfg_t      timing,
  output lane_stat_t       stat
);

  logic [COUNT_BITS-1:0] press_r, press_nxt;
  logic [REL_W-1:0]      rel_r, rel_nxt;
  logic                  long_r, long_nxt;

  logic                  pressed;
  logic [COUNT_BITS-1:0] cnt_inc, cnt_p, limit_ext, reload_ext;
  logic [REL_W-1:0]      rel_inc;
  logic                  ev, lg;

  assign pressed    = ((~raw_keys & mask) == mask);
  assign cnt_inc    = (&press_r) ? press_r : press_r + 1'b1;
  assign cnt_p      = combo_clr ? '0 : cnt_inc;
  assign limit_ext  = COUNT_BITS'(timing.long_limit);
  assign reload_ext = COUNT_BITS'(timing.reload);
  assign rel_inc    = (rel_r == REL_MAX) ? rel_r : rel_r + 1'b1;

  always_comb begin
    press_nxt = press_r;
    rel_nxt   = rel_r;
    long_nxt  = long_r;
    ev        = 1'b0;
    lg        = 1'b0;
    if (pressed) begin
      press_nxt = cnt_p;
      if (cnt_p > COUNT_BITS'(FILTER_TICKS)) begin
        rel_nxt = '0;
        if (cnt_p > limit_ext) begin
          // Long press: flag it and pull the counter back for auto-repeat
          long_nxt  = 1'b1;
          press_nxt = reload_ext;
          ev        = 1'b1;
          lg        = 1'b1;
        end
      end
    end else begin
      rel_nxt = rel_inc;
      if (rel_inc > REL_W'(FILTER_TICKS)) begin
        if (!long_r && press_r > COUNT_BITS'(SHORT_TICKS) && press_r < limit_ext) begin
          ev = 1'b1;
        end
        press_nxt = '0;
        long_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_r <= '0;
      rel_r   <= '0;
      long_r  <= 1'b0;
    end else if (step) begin
      press_r <= press_nxt;
      rel_r   <= rel_nxt;
      long_r  <= long_nxt;
    end
  end

  assign stat.ev     = step & ev;
  assign stat.lg     = step & lg;
  assign stat.active = (press_r != '0);

endmodule

>>> rtl/kpc_merge.sv
// Merge of lane results into event masks, with output register and skid stage.
`timescale 1ns / 1ps

module kpc_merge import kpc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  lane_stat_t stat [NUM_KEYS],
  output logic       push_ready,
  kpc_out_if.source  out_ch
);

  logic [NUM_KEYS-1:0] ev_in, lg_in;
  logic                pop;

  logic                out_vld_r, out_vld_nxt;
  logic                skid_vld_r, skid_vld_nxt;
  logic [NUM_KEYS-1:0] out_ev_r, out_ev_nxt, out_lg_r, out_lg_nxt;
  logic [NUM_KEYS-1:0] skid_ev_r, skid_ev_nxt, skid_lg_r, skid_lg_nxt;

  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      ev_in[k] = stat[k].ev;
      lg_in[k] = stat[k].lg;
    end
  end

  assign pop        = out_vld_r & out_ch.ready;
  assign push_ready = ~skid_vld_r;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    out_ev_nxt   = out_ev_r;
    out_lg_nxt   = out_lg_r;
    skid_ev_nxt  = skid_ev_r;
    skid_lg_nxt  = skid_lg_r;
    if (!out_vld_r || pop) begin
      if (skid_vld_r) begin
        // Drain the skid beat; no push can arrive while it is full
        out_vld_nxt  = 1'b1;
        out_ev_nxt   = skid_ev_r;
        out_lg_nxt   = skid_lg_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt = push;
        out_ev_nxt  = ev_in;
        out_lg_nxt  = lg_in;
      end
    end else if (push) begin
      // Output stalled: hold the new beat in the skid stage
      skid_vld_nxt = 1'b1;
      skid_ev_nxt  = ev_in;
      skid_lg_nxt  = lg_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_ev_r  <= out_ev_nxt;
    out_lg_r  <= out_lg_nxt;
    skid_ev_r <= skid_ev_nxt;
    skid_lg_r <= skid_lg_nxt;
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.event_mask = out_ev_r;
  assign out_ch.long_mask  = out_lg_r;

endmodule

>>> rtl/keypad_press_classifier.sv
// Top level of the keypad press classifier: registers, six key lanes, merge.
`timescale 1ns / 1ps
//
//  port group   dir   handshake          payload
//  in_ch        in    valid / ready      raw_keys (5 pins, active low)
//  out_ch       out   valid / ready      event_mask, long_mask (6 bits each)
//  cfg_*        in    APB psel/penable   8 registers at byte address 4*i
//
//  One pin sample per cycle while in_ch.ready is high: all six lanes update at the edge
//  that accepts the beat, and the merged masks load into the output register at that same
//  edge if it is empty or being read, so the result is valid on out_ch in the next cycle.
//  The output register plus one skid stage let in_ch accept while a result
//  waits; in_ch.ready drops only when both hold a beat.
//  rst_n is synchronous: counters, flags and valids clear, registers take
//  their default masks and timing.

module keypad_press_classifier import kpc_pkg::*; #(
  parameter int COUNT_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  kpc_in_if.sink            in_ch,
  kpc_out_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [PIN_W-1:0]    key_mask [NUM_KEYS];
  timing_cfg_t         timing;
  lane_stat_t          stat [NUM_KEYS];
  logic [NUM_KEYS-1:0] combo_clr;
  logic                push_ready;
  logic                step;

  kpc_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .key_mask    (key_mask),
    .timing      (timing)
  );

  assign in_ch.ready = push_ready;
  assign step        = in_ch.valid & push_ready;

  // Combination members drop their count while the combination counter is live
  always_comb begin
    combo_clr                 = '0;
    combo_clr[KEY_C1]         = stat[KEY_C1_C2].active | stat[KEY_C1_ADVANCE].active;
    combo_clr[KEY_C2]         = stat[KEY_C1_C2].active;
    combo_clr[KEY_ADVANCE]    = stat[KEY_C1_ADVANCE].active;
  end

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    kpc_lane #(
      .COUNT_BITS (COUNT_BITS)
    ) u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .step      (step),
      .raw_keys  (in_ch.raw_keys),
      .mask      (key_mask[k]),
      .combo_clr (combo_clr[k]),
      .timing    (timing),
      .stat      (stat[k])
    );
  end

  kpc_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (step),
    .stat       (stat),
    .push_ready (push_ready),
    .out_ch     (out_ch)
  );

  a_long_is_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.long_mask & ~out_ch.event_mask) == '0))
    else $error("long bit set without event bit");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid)
    else $error("input stalled while output register empty");

  a_reset_clears_valid: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");

  a_combo_clears_member: assert property (@(posedge clk) disable iff (!rst_n)
    step && stat[KEY_C1_C2].active && ((~in_ch.raw_keys & key_mask[KEY_C2]) == key_mask[KEY_C2])
    |-> !stat[KEY_C2].ev)
    else $error("C2 reported an event while its combination was active");

endmodule
